### sv/stk_pkg.sv
// shared types and constants for the script tokenizer
// token kinds, token beat layout and the result queue geometry; no dependencies

package stk_pkg;

    localparam int POS_WIDTH_DEF = 16;

    // result queue holds two beats per byte plus slack for one byte in flight
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef enum logic [4:0] {
        KIND_ILLEGAL   = 5'd0,
        KIND_EOI       = 5'd1,
        KIND_IDENT     = 5'd2,
        KIND_INT       = 5'd3,
        KIND_STRING    = 5'd4,
        KIND_ASSIGN    = 5'd5,
        KIND_EQ        = 5'd6,
        KIND_BANG      = 5'd7,
        KIND_NOT_EQ    = 5'd8,
        KIND_LT        = 5'd9,
        KIND_GT        = 5'd10,
        KIND_PLUS      = 5'd11,
        KIND_MINUS     = 5'd12,
        KIND_STAR      = 5'd13,
        KIND_SLASH     = 5'd14,
        KIND_LPAREN    = 5'd15,
        KIND_RPAREN    = 5'd16,
        KIND_LBRACE    = 5'd17,
        KIND_RBRACE    = 5'd18,
        KIND_COMMA     = 5'd19,
        KIND_SEMICOLON = 5'd20
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } t_token;

    // up to two tokens produced by one accepted byte
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token tok0;
        t_token tok1;
    } t_push;

endpackage

### sv/stk_scan.sv
// per-byte scanner: mode, position, token start and length registers plus next-token decode
// depends on stk_pkg for token kinds and the push struct

module stk_scan
    import stk_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char,
    output t_push      o_push
);

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_UNDER = 8'h5f;

    typedef enum logic [5:0] {
        MODE_IDLE      = 6'b000001,
        MODE_IDENT     = 6'b000010,
        MODE_NUMBER    = 6'b000100,
        MODE_STRING    = 6'b001000,
        MODE_PEND_EQ   = 6'b010000,
        MODE_PEND_BANG = 6'b100000
    } t_mode;

    typedef enum logic [2:0] {
        CLS_WS, CLS_END, CLS_LETTER, CLS_DIGIT, CLS_QUOTE, CLS_EQ, CLS_BANG, CLS_OTHER
    } t_cls;

    function automatic t_cls char_class(input logic [7:0] c);
        t_cls cls;
        case (c) inside
            CH_SPACE, CH_TAB, CH_CR, CH_LF:        cls = CLS_WS;
            CH_NUL:                                cls = CLS_END;
            [8'h61:8'h7a], [8'h41:8'h5a], CH_UNDER: cls = CLS_LETTER;
            [8'h30:8'h39]:                         cls = CLS_DIGIT;
            CH_QUOTE:                              cls = CLS_QUOTE;
            CH_EQ:                                 cls = CLS_EQ;
            CH_BANG:                               cls = CLS_BANG;
            default:                               cls = CLS_OTHER;
        endcase
        return cls;
    endfunction

    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            8'h3c:   k = KIND_LT;
            8'h3e:   k = KIND_GT;
            8'h2b:   k = KIND_PLUS;
            8'h2d:   k = KIND_MINUS;
            8'h2a:   k = KIND_STAR;
            8'h2f:   k = KIND_SLASH;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7b:   k = KIND_LBRACE;
            8'h7d:   k = KIND_RBRACE;
            8'h2c:   k = KIND_COMMA;
            8'h3b:   k = KIND_SEMICOLON;
            default: k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

    function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
        return (v == POS_MAX) ? POS_MAX : v + 1'b1;
    endfunction

    t_mode                r_mode, n_mode;
    logic [POS_WIDTH-1:0] r_pos;
    logic [POS_WIDTH-1:0] r_begin, n_begin;
    logic [POS_WIDTH-1:0] r_len, n_len;

    t_cls                 cls;

    // what the byte does when seen between tokens
    logic                 id_v;
    t_kind                id_kind;
    logic [15:0]          id_len;
    t_mode                id_mode;
    logic [POS_WIDTH-1:0] id_begin;
    logic [POS_WIDTH-1:0] id_rlen;
    logic                 id_eoi;

    // token that closes the pending run
    logic                 first_v;
    t_kind                first_kind;
    logic [15:0]          first_len;
    logic                 do_idle;
    logic                 eoi;
    logic                 more;

    assign cls = char_class(i_char);

    always_comb begin
        id_v     = 1'b0;
        id_kind  = KIND_ILLEGAL;
        id_len   = 16'd1;
        id_mode  = MODE_IDLE;
        id_begin = r_begin;
        id_rlen  = r_len;
        id_eoi   = 1'b0;
        case (cls)
            CLS_WS: begin
            end
            CLS_END: begin
                id_v    = 1'b1;
                id_kind = KIND_EOI;
                id_len  = 16'd0;
                id_eoi  = 1'b1;
            end
            CLS_LETTER, CLS_DIGIT: begin
                id_mode  = (cls == CLS_LETTER) ? MODE_IDENT : MODE_NUMBER;
                id_begin = r_pos;
                id_rlen  = POS_WIDTH'(1);
            end
            CLS_QUOTE: begin
                // string text starts after the opening quote
                id_mode  = MODE_STRING;
                id_begin = sat_inc(r_pos);
                id_rlen  = '0;
            end
            CLS_EQ, CLS_BANG: begin
                id_mode  = (cls == CLS_EQ) ? MODE_PEND_EQ : MODE_PEND_BANG;
                id_begin = r_pos;
                id_rlen  = POS_WIDTH'(1);
            end
            default: begin
                id_v    = 1'b1;
                id_kind = single_kind(i_char);
            end
        endcase
    end

    always_comb begin
        first_v    = 1'b0;
        first_kind = KIND_ILLEGAL;
        first_len  = 16'(r_len);
        do_idle    = 1'b0;
        more       = 1'b0;
        n_mode     = r_mode;
        n_begin    = r_begin;
        n_len      = r_len;
        unique case (r_mode)
            MODE_IDENT, MODE_NUMBER: begin
                more = (r_mode == MODE_IDENT) ? (cls == CLS_LETTER) : (cls == CLS_DIGIT);
                if (more) begin
                    n_len = sat_inc(r_len);
                end else begin
                    first_v    = 1'b1;
                    first_kind = (r_mode == MODE_IDENT) ? KIND_IDENT : KIND_INT;
                    do_idle    = 1'b1;
                end
            end
            MODE_STRING: begin
                if (cls == CLS_QUOTE) begin
                    first_v    = 1'b1;
                    first_kind = KIND_STRING;
                    n_mode     = MODE_IDLE;
                end else if (cls == CLS_END) begin
                    // end of input inside a string: string token then eoi
                    first_v    = 1'b1;
                    first_kind = KIND_STRING;
                    do_idle    = 1'b1;
                end else begin
                    n_len = sat_inc(r_len);
                end
            end
            MODE_PEND_EQ, MODE_PEND_BANG: begin
                first_v = 1'b1;
                if (cls == CLS_EQ) begin
                    first_kind = (r_mode == MODE_PEND_EQ) ? KIND_EQ : KIND_NOT_EQ;
                    first_len  = 16'd2;
                    n_mode     = MODE_IDLE;
                end else begin
                    first_kind = (r_mode == MODE_PEND_EQ) ? KIND_ASSIGN : KIND_BANG;
                    first_len  = 16'd1;
                    do_idle    = 1'b1;
                end
            end
            default: begin
                do_idle = 1'b1;
            end
        endcase
        if (do_idle) begin
            n_mode  = id_mode;
            n_begin = id_begin;
            n_len   = id_rlen;
        end
    end

    assign eoi = do_idle & id_eoi;

    always_comb begin
        t_token ftok;
        t_token itok;
        ftok.kind   = first_kind;
        ftok.start  = 16'(r_begin);
        ftok.length = first_len;
        ftok.last   = 1'b0;
        itok.kind   = id_kind;
        itok.start  = 16'(r_pos);
        itok.length = id_len;
        itok.last   = 1'b1;

        o_push.v0   = i_accept & (first_v | (do_idle & id_v));
        o_push.v1   = i_accept & first_v & do_idle & id_v;
        o_push.tok0 = first_v ? ftok : itok;
        o_push.tok0.last = !(first_v & do_idle & id_v);
        o_push.tok1 = itok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pos   <= '0;
            r_begin <= '0;
            r_len   <= '0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_pos   <= eoi ? '0 : sat_inc(r_pos);
            r_begin <= n_begin;
            r_len   <= n_len;
        end
    end

    // a zero byte always ends the input and restarts the position
    a_eoi_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_char == CH_NUL) |=> (r_pos == '0))
        else $error("position not restarted after end of input");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.v1 |-> (o_push.v0 && !o_push.tok0.last && o_push.tok1.last))
        else $error("two-token beat pair malformed");

    a_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_char == CH_NUL) |-> (o_push.v0 && (o_push.v1 ?
            o_push.tok1.kind == KIND_EOI : o_push.tok0.kind == KIND_EOI)))
        else $error("end of input produced no eoi token");

endmodule

### sv/stk_queue.sv
// result queue: buffers up to Q_DEPTH token beats, takes one or two per cycle
// depends on stk_pkg for the token and push structs

module stk_queue
    import stk_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_out_stall,
    output logic   o_in_stall,
    output logic   o_out_valid,
    output t_token o_tok
);

    t_token            r_q [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr;
    logic [Q_AW-1:0]   r_rd;
    logic [Q_CW-1:0]   r_count, n_count;
    logic              pop;
    logic [Q_CW-1:0]   push_n;

    assign o_out_valid = (r_count != '0);
    assign o_tok       = r_q[r_rd];
    assign pop         = o_out_valid & !i_out_stall;
    // room for the worst case of two beats from the next byte
    assign o_in_stall  = (r_count > Q_CW'(Q_DEPTH - 2));

    assign push_n  = Q_CW'(i_push.v0) + Q_CW'(i_push.v1);
    assign n_count = r_count + push_n - Q_CW'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.v0) begin
            r_q[r_wr] <= i_push.tok0;
        end
        if (i_push.v1) begin
            r_q[r_wr + Q_AW'(1)] <= i_push.tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + push_n[Q_AW-1:0];
            r_rd    <= r_rd + Q_AW'(pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.v0 |-> (r_count + push_n <= Q_CW'(Q_DEPTH)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_push.v0 && pop) |=> (r_count == $past(r_count) - 1'b1))
        else $error("queue count lost a beat");

endmodule

### sv/script_tokenizer.sv
// top level of the script tokenizer: byte scanner followed by the token queue
// depends on stk_pkg, stk_scan and stk_queue

// Streaming tokenizer: one source byte per input beat, one token per output beat
// (kind, start position, length; the consumer keeps the text). A byte is decoded in
// the cycle it is accepted and its tokens land in a four-entry result queue, so bytes
// are taken back to back at one per cycle while input stall is low. A byte can close
// a run and also be a one-byte token or EOI, giving two beats; the output drains one
// beat per cycle while output stall is low, so stretches of such bytes are limited
// by the output side and input stall rises once fewer than two queue slots are free.
// Byte 0 ends the input with an EOI token and restarts the position at 0. Positions
// and lengths saturate at 2^POS_WIDTH-1 and the outputs carry their low 16 bits.

module script_tokenizer
    import stk_pkg::*;
#(
    parameter int POS_WIDTH = POS_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [4:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);

    logic   accept;
    t_push  push;
    t_token tok;

    assign accept = i_in_valid & !o_in_stall;

    stk_scan #(
        .POS_WIDTH (POS_WIDTH)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_char   (i_char_in),
        .o_push   (push)
    );

    stk_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_tok       (tok)
    );

    assign o_token_kind   = tok.kind;
    assign o_token_start  = tok.start;
    assign o_token_length = tok.length;
    assign o_last_of_run  = tok.last;

endmodule
